@@ rtl/pli_pkg.sv @@
// package for the piecewise linear interpolator
// holds widths, status codes and the front-to-back command type; no dependencies
package pli_pkg;
	localparam int DEF_TABLE_DEPTH = 16;
	localparam int VAL_W = 32;
	localparam int CFG_W = 5;
	localparam int IDX_W = 4;
	localparam int FRAC_BITS = 16;

	typedef enum logic [1:0] {
		ST_BELOW  = 2'd0,
		ST_ABOVE  = 2'd1,
		ST_INTERP = 2'd2,
		ST_HELD   = 2'd3
	} status_t;

	// command handed from front to back
	typedef struct packed {
		logic              interp;   // 0: plain result, 1: blend needed
		status_t           status;
		logic signed [VAL_W-1:0] k1;
		logic signed [VAL_W-1:0] k2;
		logic signed [VAL_W-1:0] v1;
		logic signed [VAL_W-1:0] v2;
		logic signed [VAL_W-1:0] f;
		logic              held;     // answer with last level
	} cmd_t;
endpackage

@@ rtl/pli_if.sv @@
// valid/ready channel interfaces for input items and results
// depends on pli_pkg
interface pli_in_if;
	logic ready;
	logic valid;
	logic [0:0] mode;
	logic [pli_pkg::IDX_W-1:0] entry_index;
	logic signed [pli_pkg::VAL_W-1:0] key_point;
	logic signed [pli_pkg::VAL_W-1:0] key_level;
	logic signed [pli_pkg::VAL_W-1:0] fraction;
	modport source (output valid, mode, entry_index, key_point, key_level, fraction,
		input ready);
	modport sink (input valid, mode, entry_index, key_point, key_level, fraction,
		output ready);
endinterface

interface pli_out_if;
	logic ready;
	logic valid;
	logic signed [pli_pkg::VAL_W-1:0] level_out;
	logic [1:0] status;
	modport source (output valid, level_out, status, input ready);
	modport sink (input valid, level_out, status, output ready);
endinterface

@@ rtl/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator. Mode-0 items write one key/level pair into
// the table. In the front, a mode-1 query reads the first and last entries,
// checks the bounds, then reads and compares each interval searched; the back
// runs a 17-step restoring divide, one multiply, one add and an output register;
// front and back overlap. Depends on pli_pkg, pli_if, pli_front, pli_back.
module piecewise_linear_interpolator #(
	parameter int TABLE_DEPTH = pli_pkg::DEF_TABLE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pli_pkg::CFG_W-1:0] cfg_wdata,
	pli_in_if.sink                    in_ch,
	pli_out_if.source                 out_ch
);
	import pli_pkg::*;

	logic [CFG_W-1:0] keys_q;
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= CFG_W'(1);
		end else if (cfg_we) begin
			keys_q <= cfg_wdata;
		end
	end

	pli_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk, .arst_n, .keys_in_use(keys_q), .in_ch, .cmd_valid, .cmd_ready, .cmd);
	pli_back u_back (.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .out_ch);

	a_held_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.held |=> out_ch.valid && out_ch.status == ST_HELD)
		else $error("held command lost");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.level_out))
		else $error("result changed while stalled");
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("command dropped");
endmodule

@@ rtl/pli_ram.sv @@
// generic single-write RAM with registered read
// no dependencies
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/pli_front.sv @@
// front: accepts items, writes table, searches the interval one entry at a time
// depends on pli_pkg, pli_if, pli_ram
module pli_front #(
	parameter int TABLE_DEPTH = pli_pkg::DEF_TABLE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pli_pkg::CFG_W-1:0]  keys_in_use,
	pli_in_if.sink                     in_ch,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output pli_pkg::cmd_t              cmd
);
	import pli_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_RD0, S_RDN, S_CHK, S_SCAN, S_SCAN2, S_OUT
	} state_t;

	state_t state_q;
	logic [AW-1:0] raddr;
	logic [VAL_W-1:0] krd, vrd;
	logic signed [VAL_W-1:0] f_q, k0_q, v0_q, kp_q, vp_q;
	logic [AW-1:0] n_q, i_q;
	cmd_t cmd_q;
	logic wr_en;
	logic [CW-1:0] cnt_c;

	assign wr_en = in_ch.valid && in_ch.ready && (in_ch.mode == 1'b0) &&
		(32'(in_ch.entry_index) < 32'(TABLE_DEPTH));

	pli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_keys (
		.clk, .we(wr_en), .waddr(AW'(in_ch.entry_index)), .wdata(in_ch.key_point),
		.raddr, .rdata(krd));
	pli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_levels (
		.clk, .we(wr_en), .waddr(AW'(in_ch.entry_index)), .wdata(in_ch.key_level),
		.raddr, .rdata(vrd));

	assign in_ch.ready = (state_q == S_IDLE);
	assign cmd_valid = (state_q == S_OUT);
	assign cmd = cmd_q;

	always_comb begin
		if (keys_in_use == '0) begin
			cnt_c = CW'(1);
		end else if (32'(keys_in_use) > 32'(TABLE_DEPTH)) begin
			cnt_c = CW'(TABLE_DEPTH);
		end else begin
			cnt_c = CW'(keys_in_use);
		end
	end

	always_comb begin
		unique case (state_q)
			S_IDLE:  raddr = '0;
			S_RD0:   raddr = n_q;
			S_RDN:   raddr = n_q;
			S_CHK:   raddr = i_q;
			S_SCAN:  raddr = i_q;
			S_SCAN2: raddr = i_q;
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.mode == 1'b1) begin
					f_q <= in_ch.fraction;
					n_q <= AW'(cnt_c - CW'(1));
					state_q <= S_RD0;
				end
				S_RD0: begin
					// krd holds entry 0, entry n is being read
					k0_q <= krd;
					v0_q <= vrd;
					kp_q <= krd;
					vp_q <= vrd;
					i_q <= AW'(1);
					state_q <= S_RDN;
				end
				S_RDN: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					// krd holds entry n
					cmd_q.k1 <= '0; cmd_q.k2 <= '0; cmd_q.v2 <= '0;
					cmd_q.f <= f_q; cmd_q.held <= 1'b0; cmd_q.interp <= 1'b0;
					if (f_q < k0_q) begin
						cmd_q.v1 <= v0_q; cmd_q.status <= ST_BELOW; state_q <= S_OUT;
					end else if (f_q > $signed(krd)) begin
						cmd_q.v1 <= vrd; cmd_q.status <= ST_ABOVE; state_q <= S_OUT;
					end else if (n_q == '0) begin
						cmd_q.v1 <= v0_q; cmd_q.status <= ST_INTERP; state_q <= S_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// address i_q issued, data arrives in S_SCAN2
					state_q <= S_SCAN2;
				end
				S_SCAN2: begin
					if (kp_q <= f_q && f_q <= $signed(krd)) begin
						cmd_q.k1 <= kp_q; cmd_q.k2 <= krd;
						cmd_q.v1 <= vp_q; cmd_q.v2 <= vrd;
						cmd_q.interp <= 1'b1; cmd_q.status <= ST_INTERP;
						state_q <= S_OUT;
					end else if (i_q == n_q) begin
						cmd_q.held <= 1'b1; cmd_q.status <= ST_HELD;
						state_q <= S_OUT;
					end else begin
						kp_q <= krd; vp_q <= vrd;
						i_q <= i_q + AW'(1);
						state_q <= S_SCAN;
					end
				end
				S_OUT: if (cmd_ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/pli_back.sv @@
// back: radix-2 divide for the weight, one multiply, one add, output register
// depends on pli_pkg, pli_if
module pli_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pli_pkg::cmd_t cmd,
	pli_out_if.source     out_ch
);
	import pli_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_ADD, S_OUT} state_t;

	state_t state_q;
	logic [32:0] span_q, rem_q;
	logic [16:0] quo_q;
	logic [4:0] cnt_q;
	logic signed [VAL_W-1:0] v1_q, last_q;
	logic signed [32:0] dv_q;
	logic signed [50:0] prod_q;
	logic signed [VAL_W-1:0] lvl_q;
	status_t st_q;
	logic [33:0] trial;

	assign cmd_ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.level_out = lvl_q;
	assign out_ch.status = st_q;
	assign trial = {1'b0, rem_q} - {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd_valid) begin
					st_q <= cmd.status;
					v1_q <= cmd.v1;
					dv_q <= 33'(cmd.v2) - 33'(cmd.v1);
					span_q <= 33'(cmd.k2) - 33'(cmd.k1);
					rem_q <= 33'(cmd.f) - 33'(cmd.k1);
					quo_q <= '0;
					cnt_q <= '0;
					if (cmd.held) begin
						lvl_q <= last_q; state_q <= S_OUT;
					end else if (!cmd.interp || (33'(cmd.k2) - 33'(cmd.k1)) == '0) begin
						lvl_q <= cmd.v1; last_q <= cmd.v1; state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// d <= span, so 17 quotient bits cover d*65536/span
					if (!trial[33]) begin
						rem_q <= {trial[31:0], 1'b0}; quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						rem_q <= {rem_q[31:0], 1'b0}; quo_q <= {quo_q[15:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= $signed({1'b0, (quo_q[16] ? 16'hFFFF : quo_q[15:0])}) * dv_q;
					state_q <= S_ADD;
				end
				S_ADD: begin
					lvl_q <= VAL_W'(51'(v1_q) + (prod_q >>> FRAC_BITS));
					last_q <= VAL_W'(51'(v1_q) + (prod_q >>> FRAC_BITS));
					state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
